// File: rtl/pqms_pkg.sv
package pqms_pkg;

    // Fixed field widths of the request and result transfers.
    localparam int ITEM_W   = 32;
    localparam int PRIO_W   = 32;
    localparam int STATUS_W = 2;

    // Width of one stored entry: priority in the upper half, item below it.
    localparam int ENTRY_W = PRIO_W + ITEM_W;

    // Request codes.
    typedef enum logic {
        REQ_ENQUEUE = 1'b0,
        REQ_DEQUEUE = 1'b1
    } req_t;

    // Result status codes.
    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK    = 2'd0,
        STATUS_FULL  = 2'd1,
        STATUS_EMPTY = 2'd2
    } status_t;

endpackage

// File: rtl/pqms_ram.sv
module pqms_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Single write port and a single registered read port.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: rtl/priority_queue_min_stable_unit.sv
// Bounded minimum-priority queue holding up to DEPTH entries in one RAM, kept
// sorted by signed priority with ties served first in, first out. Each request
// gives exactly one result. A full enqueue or an empty dequeue answers without
// touching the RAM. An enqueue moves the entries of larger priority one place
// back, one at a time, and a dequeue shifts the entries behind the head forward
// one at a time. The pace of both is set by the single RAM read port and its
// registered read data: each step of the sequencer reads one entry, for an
// enqueue compares it in the priority comparator, and writes it back one place
// along. The block is not ready while a request is at work; a finished result
// waits in the output register until taken.
module priority_queue_min_stable_unit #(
    parameter int DEPTH = 16
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic                         s_req_type,
    input  logic signed [31:0]           s_item_value,
    input  logic signed [31:0]           s_priority_req,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [1:0]                   m_status,
    output logic signed [31:0]           m_out_value
);

    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [CNT_W-1:0] ONE_C  = CNT_W'(1);
    localparam logic [CNT_W-1:0] FULL_C = CNT_W'(DEPTH);

    // Sequencer states.
    typedef enum logic [5:0] {
        ST_IDLE     = 6'b000001,
        ST_ENQ_RD   = 6'b000010,
        ST_ENQ_CMP  = 6'b000100,
        ST_DEQ_HEAD = 6'b001000,
        ST_DEQ_RD   = 6'b010000,
        ST_DEQ_WR   = 6'b100000
    } state_t;

    state_t                              state_reg, state_next;
    logic                                resp_reg, resp_next;
    logic [CNT_W-1:0]                    count_reg, count_next;
    logic [CNT_W-1:0]                    pos_reg, pos_next;
    logic [pqms_pkg::ITEM_W-1:0]         item_reg, item_next;
    logic [pqms_pkg::PRIO_W-1:0]         prio_reg, prio_next;
    pqms_pkg::status_t                   res_status_reg, res_status_next;
    logic [pqms_pkg::ITEM_W-1:0]         res_value_reg, res_value_next;
    logic                                m_valid_reg, m_valid_next;
    pqms_pkg::status_t                   m_status_reg, m_status_next;
    logic [pqms_pkg::ITEM_W-1:0]         m_value_reg, m_value_next;

    logic                                wr_en;
    logic [IDX_W-1:0]                    wr_addr;
    logic [pqms_pkg::ENTRY_W-1:0]        wr_data;
    logic                                rd_en;
    logic [IDX_W-1:0]                    rd_addr;
    logic [pqms_pkg::ENTRY_W-1:0]        rd_data;
    logic [CNT_W-1:0]                    pos_dec;
    logic signed [pqms_pkg::PRIO_W-1:0]  rd_prio;
    logic                                prio_gt;
    logic                                s_accept;

    pqms_ram #(
        .WIDTH (pqms_pkg::ENTRY_W),
        .DEPTH (DEPTH)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign s_ready  = (state_reg == ST_IDLE) && !resp_reg;
    assign s_accept = s_valid && s_ready;
    assign pos_dec  = pos_reg - ONE_C;

    // Priority comparator: is the stored priority strictly greater than the new one?
    assign rd_prio = $signed(rd_data[pqms_pkg::ENTRY_W-1:pqms_pkg::ITEM_W]);
    assign prio_gt = rd_prio > $signed(prio_reg);

    // Sequencer and RAM port control.
    always_comb begin
        state_next      = state_reg;
        resp_next       = resp_reg;
        count_next      = count_reg;
        pos_next        = pos_reg;
        item_next       = item_reg;
        prio_next       = prio_reg;
        res_status_next = res_status_reg;
        res_value_next  = res_value_reg;
        wr_en           = 1'b0;
        wr_addr         = pos_reg[IDX_W-1:0];
        wr_data         = {prio_reg, item_reg};
        rd_en           = 1'b0;
        rd_addr         = pos_dec[IDX_W-1:0];

        case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    item_next      = s_item_value;
                    prio_next      = s_priority_req;
                    res_value_next = '0;
                    if (s_req_type == pqms_pkg::REQ_ENQUEUE) begin
                        if (count_reg == FULL_C) begin
                            res_status_next = pqms_pkg::STATUS_FULL;
                            resp_next       = 1'b1;
                        end else begin
                            pos_next   = count_reg;
                            state_next = ST_ENQ_RD;
                        end
                    end else begin
                        if (count_reg == '0) begin
                            res_status_next = pqms_pkg::STATUS_EMPTY;
                            resp_next       = 1'b1;
                        end else begin
                            // Fetch the head entry.
                            rd_en      = 1'b1;
                            rd_addr    = '0;
                            state_next = ST_DEQ_HEAD;
                        end
                    end
                end
            end
            ST_ENQ_RD: begin
                if (pos_reg == '0) begin
                    wr_en           = 1'b1;
                    count_next      = count_reg + ONE_C;
                    res_status_next = pqms_pkg::STATUS_OK;
                    resp_next       = 1'b1;
                    state_next      = ST_IDLE;
                end else begin
                    rd_en      = 1'b1;
                    state_next = ST_ENQ_CMP;
                end
            end
            ST_ENQ_CMP: begin
                wr_en = 1'b1;
                if (prio_gt) begin
                    // Move the larger entry one place back and keep searching.
                    wr_data    = rd_data;
                    pos_next   = pos_dec;
                    state_next = ST_ENQ_RD;
                end else begin
                    count_next      = count_reg + ONE_C;
                    res_status_next = pqms_pkg::STATUS_OK;
                    resp_next       = 1'b1;
                    state_next      = ST_IDLE;
                end
            end
            ST_DEQ_HEAD: begin
                res_value_next  = rd_data[pqms_pkg::ITEM_W-1:0];
                res_status_next = pqms_pkg::STATUS_OK;
                pos_next        = ONE_C;
                state_next      = ST_DEQ_RD;
            end
            ST_DEQ_RD: begin
                if (pos_reg == count_reg) begin
                    count_next = count_reg - ONE_C;
                    resp_next  = 1'b1;
                    state_next = ST_IDLE;
                end else begin
                    rd_en      = 1'b1;
                    rd_addr    = pos_reg[IDX_W-1:0];
                    state_next = ST_DEQ_WR;
                end
            end
            ST_DEQ_WR: begin
                // Shift the fetched entry one place towards the head.
                wr_en      = 1'b1;
                wr_addr    = pos_dec[IDX_W-1:0];
                wr_data    = rd_data;
                pos_next   = pos_reg + ONE_C;
                state_next = ST_DEQ_RD;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        // Hand the finished result to the output register once it is free.
        m_valid_next  = m_valid_reg;
        m_status_next = m_status_reg;
        m_value_next  = m_value_reg;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        if (resp_reg && (!m_valid_reg || m_ready)) begin
            m_valid_next  = 1'b1;
            m_status_next = res_status_reg;
            m_value_next  = res_value_reg;
            resp_next     = 1'b0;
        end
    end

    // Control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            resp_reg    <= 1'b0;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            resp_reg    <= resp_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        pos_reg        <= pos_next;
        item_reg       <= item_next;
        prio_reg       <= prio_next;
        res_status_reg <= res_status_next;
        res_value_reg  <= res_value_next;
        m_status_reg   <= m_status_next;
        m_value_reg    <= m_value_next;
    end

    assign m_valid     = m_valid_reg;
    assign m_status    = m_status_reg;
    assign m_out_value = $signed(m_value_reg);

endmodule
